[sv/utf8_to_utf16_decoder_macros.svh]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder assertion macros
// Shared property wrappers clocked on clk_i; U8U16_ASSERT is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

// Checked only while the block is out of reset.
`define U8U16_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, during reset as well.
`define U8U16_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Types and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam logic [15:0] HiSurBase = 16'hD800;
  localparam logic [15:0] LoSurBase = 16'hDC00;
  localparam logic [20:0] SurFirst  = 21'h00D800;
  localparam logic [20:0] SurLast   = 21'h00DFFF;
  localparam logic [20:0] SupFirst  = 21'h010000;
  localparam logic [20:0] SupLast   = 21'h10FFFF;

  localparam logic [1:0] SeqNone  = 2'd0;
  localparam logic [1:0] SeqTwo   = 2'd1;
  localparam logic [1:0] SeqThree = 2'd2;
  localparam logic [1:0] SeqFour  = 2'd3;

  typedef struct packed {
    logic [1:0]  cnt;
    logic [15:0] unit0;
    logic        last0;
    logic [15:0] unit1;
  } result_t;

endpackage

[sv/u8u16_dec.sv]
// ----------------------------------------------------------------------------
// UTF-8 sequence decoder
// Holds the open sequence and turns one byte into zero, one or two code units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8u16_dec (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [7:0]              byte_i,
  input  logic                    advance_i,
  output u8u16_pkg::result_t      result_o
);

  logic [1:0]  owed_q, owed_d;
  logic [1:0]  seq_q, seq_d;
  logic [20:0] pcp_q, pcp_d;
  logic [20:0] cp;
  logic [19:0] sup;
  logic [1:0]  owed_dec;

  assign cp       = {pcp_q[14:0], byte_i[5:0]};
  assign sup      = 20'(cp - u8u16_pkg::SupFirst);
  assign owed_dec = owed_q - 2'd1;

  always_comb begin
    owed_d          = owed_q;
    seq_d           = seq_q;
    pcp_d           = pcp_q;
    result_o.cnt    = 2'd0;
    result_o.unit0  = {8'd0, byte_i};
    result_o.last0  = 1'b1;
    result_o.unit1  = 16'(u8u16_pkg::LoSurBase + {6'd0, sup[9:0]});
    if (owed_q == 2'd0) begin
      if (byte_i == 8'h00) begin
        seq_d = u8u16_pkg::SeqNone;
        pcp_d = '0;
      end else if (byte_i inside {[8'h01 : 8'h7F]}) begin
        result_o.cnt = 2'd1;
      end else if (byte_i inside {[8'hC0 : 8'hDF]}) begin
        pcp_d  = {16'd0, byte_i[4:0]};
        owed_d = 2'd1;
        seq_d  = u8u16_pkg::SeqTwo;
      end else if (byte_i inside {[8'hE0 : 8'hEF]}) begin
        pcp_d  = {17'd0, byte_i[3:0]};
        owed_d = 2'd2;
        seq_d  = u8u16_pkg::SeqThree;
      end else if (byte_i inside {[8'hF0 : 8'hF7]}) begin
        pcp_d  = {18'd0, byte_i[2:0]};
        owed_d = 2'd3;
        seq_d  = u8u16_pkg::SeqFour;
      end
    end else begin
      owed_d = owed_dec;
      if (owed_dec != 2'd0) begin
        pcp_d = cp;
      end else begin
        seq_d = u8u16_pkg::SeqNone;
        pcp_d = '0;
        case (seq_q)
          u8u16_pkg::SeqTwo: begin
            result_o.cnt   = 2'd1;
            result_o.unit0 = cp[15:0];
          end
          u8u16_pkg::SeqThree: begin
            result_o.unit0 = cp[15:0];
            if (cp < u8u16_pkg::SurFirst || cp > u8u16_pkg::SurLast) begin
              result_o.cnt = 2'd1;
            end
          end
          u8u16_pkg::SeqFour: begin
            result_o.unit0 = 16'(u8u16_pkg::HiSurBase + {6'd0, sup[19:10]});
            result_o.last0 = 1'b0;
            if (cp >= u8u16_pkg::SupFirst && cp <= u8u16_pkg::SupLast) begin
              result_o.cnt = 2'd2;
            end
          end
          default: begin
            result_o.cnt = 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= 2'd0;
      seq_q  <= u8u16_pkg::SeqNone;
      pcp_q  <= '0;
    end else if (advance_i) begin
      owed_q <= owed_d;
      seq_q  <= seq_d;
      pcp_q  <= pcp_d;
    end
  end

endmodule

[sv/utf8_to_utf16_decoder.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder
// Streams UTF-8 bytes in and UTF-16 code units out, surrogate pairs included.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while the output register can take its
// code units; a byte is held in the input register and its units in the output
// register. A byte that ends a supplementary code point yields a high and then
// a low surrogate; the two-entry output register holds the pair, so a later
// byte that yields a unit waits in the input register until the low surrogate
// is being taken.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] code_unit
  output logic        m_axis_tlast_o    // run_last
);

  `include "utf8_to_utf16_decoder_macros.svh"

  logic               in_vld_q;
  logic [7:0]         in_byte_q;
  logic [1:0]         out_cnt_q;
  logic [15:0]        slot0_q;
  logic               last0_q;
  logic [15:0]        slot1_q;
  u8u16_pkg::result_t res;
  logic               pop;
  logic               out_free;
  logic               advance;
  logic               load;
  logic               slot0_hi;

  u8u16_dec u_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (in_byte_q),
    .advance_i (advance),
    .result_o  (res)
  );

  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign out_free        = (out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && m_axis_tready_i);
  assign advance         = in_vld_q && ((res.cnt == 2'd0) || out_free);
  assign load            = advance && (res.cnt != 2'd0);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign m_axis_tvalid_o = out_cnt_q != 2'd0;
  assign m_axis_tdata_o  = slot0_q;
  assign m_axis_tlast_o  = last0_q;
  assign slot0_hi        = slot0_q[15:10] == 6'b110110;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_cnt_q <= 2'd0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (load) begin
        out_cnt_q <= res.cnt;
      end else if (pop) begin
        out_cnt_q <= out_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (load) begin
      slot0_q <= res.unit0;
      last0_q <= res.last0;
      slot1_q <= res.unit1;
    end else if (pop) begin
      slot0_q <= slot1_q;
      last0_q <= 1'b1;
    end
  end

  `U8U16_ASSERT_ALWAYS(a_cnt_range, !rst_ni || out_cnt_q != 2'd3, "Output count out of range.")
  `U8U16_ASSERT(a_pair_head, (out_cnt_q == 2'd2) |-> (!last0_q && slot0_hi), "Bad pair head.")
  `U8U16_ASSERT(a_not_last_hi, (m_axis_tvalid_o && !m_axis_tlast_o) |-> slot0_hi, "Bad non-last unit.")
  `U8U16_ASSERT(a_in_hold, (in_vld_q && !advance) |=> (in_vld_q && $stable(in_byte_q)), "Held input request was lost.")

endmodule

[tb/sv/utf8_to_utf16_decoder_test.sv]
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder testbench
// Streams UTF-8 bytes into the decoder and checks each UTF-16 code unit and
// its tlast flag against the bench's decode_byte model. The bytes include directed
// sequences, random well-formed sequences, noise and broken sequences. Both
// sides idle at random, and one burst runs against a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_test;

  typedef struct packed {
    logic [15:0] unit;
    logic        last;
  } code_unit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'h00;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic        m_last;

  // Decoder state as seen from the input side.
  logic [1:0]  dec_owed = 2'd0;
  logic [1:0]  dec_seq = u8u16_pkg::SeqNone;
  logic [20:0] dec_partial = 21'd0;

  code_unit_t  pending_units[$];
  int          err_count = 0;
  int          bytes_sent = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  int          hold_cycles = 0;

  utf8_to_utf16_decoder u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("utf8_to_utf16_decoder_test: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s mismatch, got %h, expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic void push_unit(input logic [15:0] unit, input logic last);
    code_unit_t cu;
    cu.unit = unit;
    cu.last = last;
    pending_units.push_back(cu);
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [20:0] offset;
    if (dec_owed == 2'd0) begin
      if (b == 8'h00) begin
        dec_seq = u8u16_pkg::SeqNone;
        dec_partial = 21'd0;
      end else if (b < 8'h80) begin
        push_unit({8'h00, b}, 1'b1);
      end else if (b < 8'hC0) begin
      end else if (b < 8'hE0) begin
        dec_partial = {16'd0, b[4:0]};
        dec_owed = 2'd1;
        dec_seq = u8u16_pkg::SeqTwo;
      end else if (b < 8'hF0) begin
        dec_partial = {17'd0, b[3:0]};
        dec_owed = 2'd2;
        dec_seq = u8u16_pkg::SeqThree;
      end else if (b < 8'hF8) begin
        dec_partial = {18'd0, b[2:0]};
        dec_owed = 2'd3;
        dec_seq = u8u16_pkg::SeqFour;
      end
    end else begin
      dec_partial = {dec_partial[14:0], b[5:0]};
      dec_owed = dec_owed - 2'd1;
      if (dec_owed == 2'd0) begin
        case (dec_seq)
          u8u16_pkg::SeqTwo: begin
            push_unit(dec_partial[15:0], 1'b1);
          end
          u8u16_pkg::SeqThree: begin
            if (dec_partial < u8u16_pkg::SurFirst || dec_partial > u8u16_pkg::SurLast) begin
              push_unit(dec_partial[15:0], 1'b1);
            end
          end
          u8u16_pkg::SeqFour: begin
            if (dec_partial >= u8u16_pkg::SupFirst && dec_partial <= u8u16_pkg::SupLast) begin
              offset = dec_partial - u8u16_pkg::SupFirst;
              push_unit(u8u16_pkg::HiSurBase + {6'd0, offset[19:10]}, 1'b0);
              push_unit(u8u16_pkg::LoSurBase + {6'd0, offset[9:0]}, 1'b1);
            end
          end
          default: begin
          end
        endcase
        dec_seq = u8u16_pkg::SeqNone;
        dec_partial = 21'd0;
      end
    end
  endfunction

  always @(posedge clk) begin
    code_unit_t want;
    if (rst_n && m_valid && m_ready) begin
      if (pending_units.size() == 0) begin
        report_mismatch("unexpected unit", m_data, 16'h0000);
      end else begin
        want = pending_units.pop_front();
        if (m_data !== want.unit) begin
          report_mismatch("code_unit", m_data, want.unit);
        end
        if (m_last !== want.last) begin
          report_mismatch("tlast", {15'd0, m_last}, {15'd0, want.last});
        end
      end
    end
  end

  // Output side: a random stall before each request while rx_idle is set, plus
  // any hold-off that a test asks for.
  initial begin
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        m_ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      stall = rx_idle ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        m_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_ready = 1'b1;
      do @(posedge clk); while (!m_valid);
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid = 1'b1;
    s_data = b;
    do @(posedge clk); while (!s_ready);
    decode_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sends the n leading bytes of word, most significant byte first.
  task automatic send_seq(input int n, input logic [31:0] word);
    for (int i = 0; i < n; i++) begin
      send_byte(word[31 - 8 * i -: 8]);
    end
  endtask

  function automatic logic [7:0] cont_byte(input logic [5:0] bits);
    logic [1:0] top;
    top = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
    return {top, bits};
  endfunction

  task automatic send_code_point(input int len, input logic [20:0] cp);
    case (len)
      1: send_byte({1'b0, cp[6:0]});
      2: send_seq(2, {3'b110, cp[10:6], cont_byte(cp[5:0]), 16'h0000});
      3: send_seq(3, {4'b1110, cp[15:12], cont_byte(cp[11:6]), cont_byte(cp[5:0]),
                      8'h00});
      default: send_seq(4, {5'b11110, cp[20:18], cont_byte(cp[17:12]),
                            cont_byte(cp[11:6]), cont_byte(cp[5:0])});
    endcase
  endtask

  task automatic wait_drained();
    s_valid = 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_ascii();
    send_seq(2, 32'h017F_0000);
  endtask

  task automatic test_two_byte();
    send_seq(4, 32'hC280_DFBF);
  endtask

  task automatic test_three_byte();
    send_seq(3, 32'hEFBF_BF00);
    send_seq(3, 32'hEDA0_8000);
  endtask

  task automatic test_four_byte();
    send_seq(4, 32'hF090_8080);
    send_seq(4, 32'hF48F_BFBF);
    send_seq(4, 32'hF490_8080);
  endtask

  task automatic test_stray_and_nul();
    send_seq(3, 32'h80FF_0000);
    send_seq(2, 32'hC300_0000);
  endtask

  task automatic test_random_stream(input int target);
    int pick;
    int start;
    logic [20:0] cp;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      pick = $urandom_range(0, 99);
      if (bytes_sent - start > target / 3 && bytes_sent - start < target / 2) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end else begin
        tx_idle = 1'b1;
        rx_idle = 1'b1;
      end
      if (pick < 15) begin
        send_code_point(1, 21'($urandom_range(1, 8'h7F)));
      end else if (pick < 35) begin
        send_code_point(2, 21'($urandom_range(0, 16'h07FF)));
      end else if (pick < 60) begin
        cp = ($urandom_range(0, 3) == 0) ? 21'($urandom_range(16'hD700, 16'hE0FF))
                                          : 21'($urandom_range(0, 16'hFFFF));
        send_code_point(3, cp);
      end else if (pick < 85) begin
        cp = ($urandom_range(0, 2) != 0)
             ? 21'($urandom_range(u8u16_pkg::SupFirst, u8u16_pkg::SupLast))
             : 21'($urandom_range(0, 21'h1FFFFF));
        send_code_point(4, cp);
      end else if (pick < 95) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(8'($urandom_range(8'hC0, 8'hF7)));
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_output_hold();
    tx_idle = 1'b0;
    hold_cycles = 300;
    repeat (40) begin
      send_code_point(4, 21'($urandom_range(u8u16_pkg::SupFirst, u8u16_pkg::SupLast)));
    end
    tx_idle = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_ascii();
    test_two_byte();
    test_three_byte();
    test_four_byte();
    test_stray_and_nul();
    wait_drained();
    test_random_stream(1300);
    wait_drained();
    test_output_hold();
    wait_drained();
    if (err_count == 0) begin
      $display("utf8_to_utf16_decoder_test: done, clean");
    end else begin
      $display("utf8_to_utf16_decoder_test: done, errors");
    end
    $finish;
  end

endmodule
